@@ sv/afd_pkg.sv @@
`default_nettype none

package afd_pkg;

  localparam int unsigned MAX_BODY_BYTES_DEF = 256 * 1024;

  // Audio body layout: type byte, 8-byte start frame, 4-byte rate, then PCM
  localparam int unsigned HDR_BYTES      = 13;
  localparam int unsigned START_LAST_IDX = 8;
  localparam int unsigned CTRL_FLAG_IDX  = 1;

  localparam logic [7:0] TYPE_AUDIO = 8'd1;
  localparam logic [7:0] TYPE_CTRL  = 8'd2;
  localparam logic [7:0] TYPE_STOP  = 8'd3;

  localparam int unsigned COUNT_W   = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int unsigned ENERGY_W  = 48;

  localparam int unsigned MIN_RATE_W = 18;
  localparam int unsigned MAX_RATE_W = 20;
  localparam logic [MIN_RATE_W-1:0] MIN_RATE_RST = MIN_RATE_W'(8000);
  localparam logic [MAX_RATE_W-1:0] MAX_RATE_RST = MAX_RATE_W'(192000);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'd1;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // sample 16 + start 64 + rate 20 + flag 1 + energy 48 + count 17, padded to bytes
  localparam int unsigned OUT_USED_W = 16 + 64 + MAX_RATE_W + 1 + ENERGY_W + COUNT_W;
  localparam int unsigned OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_STREAM,
    KIND_REPORT,
    KIND_LEN_ERR
  } kind_t;

  // Event leaving the parser
  typedef struct packed {
    kind_t                 kind;
    logic [15:0]           sample;
    logic [63:0]           start;
    logic [MAX_RATE_W-1:0] rate;
    logic                  on;
    logic [COUNT_W-1:0]    count;
    logic                  fin;
    logic                  first;
  } ev_t;

  // Queue entry: event with the running energy attached
  typedef struct packed {
    kind_t                 kind;
    logic [15:0]           sample;
    logic [63:0]           start;
    logic [MAX_RATE_W-1:0] rate;
    logic                  on;
    logic [ENERGY_W-1:0]   energy;
    logic [COUNT_W-1:0]    count;
    logic                  fin;
  } q_t;

endpackage

`default_nettype wire

@@ sv/audio_frame_deframer.sv @@
// An input transfer passes the parser event register, the square register and the queue
// to the output register. One stream byte per cycle while s_axis_tready is high; a
// frame's final sample yields two results, sent as two transfers from one queue entry.
// Input is held off once the 8-entry queue and the two stages before it hold 8 events.
// Reset (rst, synchronous): parser, streaming flag and queue cleared, output invalid,
// sample rate limits back to 8000 and 192000.
`default_nettype none

module audio_frame_deframer #(
  parameter int unsigned MAX_BODY_BYTES = afd_pkg::MAX_BODY_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // data_byte
  input  wire logic                            s_axis_tuser,   // req_type
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // sample_value[15:0], start_frame[79:16], sample_rate[99:80], streaming_on[100],
  // energy_sum[148:101], sample_count[165:149], zero pad
  output logic [afd_pkg::OUT_W-1:0]            m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,   // kind
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afd_pkg::MAX_RATE_W-1:0]  cfg_data
);
  import afd_pkg::*;

  localparam int unsigned IW = FIFO_CW + 1;

  logic [MIN_RATE_W-1:0] min_rate;
  logic [MAX_RATE_W-1:0] max_rate;

  logic               ev_valid;
  ev_t                ev;
  logic               sq_valid;
  logic               push;
  q_t                 push_data;
  logic               pop;
  q_t                 head;
  logic               head_valid;
  logic [FIFO_CW-1:0] fifo_count;
  logic [IW-1:0]      inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate <= MIN_RATE_RST;
      max_rate <= MAX_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RATE: min_rate <= cfg_data[MIN_RATE_W-1:0];
        CFG_MAX_RATE: max_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit check: every item in the two stages may still need a queue slot
  assign inflight      = IW'(fifo_count) + IW'(ev_valid) + IW'(sq_valid);
  assign s_axis_tready = (inflight < IW'(FIFO_DEPTH));

  afd_parser #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid && s_axis_tready),
    .req_type  (s_axis_tuser),
    .data_byte (s_axis_tdata),
    .min_rate  (min_rate),
    .max_rate  (max_rate),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  afd_energy u_energy (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .sq_valid  (sq_valid),
    .push      (push),
    .push_data (push_data)
  );

  afd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (fifo_count)
  );

  afd_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ sv/afd_parser.sv @@
`default_nettype none

module afd_parser #(
  parameter int unsigned MAX_BODY_BYTES = afd_pkg::MAX_BODY_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            req_type,
  input  wire logic [7:0]                      data_byte,
  input  wire logic [afd_pkg::MIN_RATE_W-1:0]  min_rate,
  input  wire logic [afd_pkg::MAX_RATE_W-1:0]  max_rate,
  output logic                                 ev_valid,
  output afd_pkg::ev_t                         ev
);
  import afd_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_BODY_BYTES + 1);
  localparam logic [31:0] MAX_LEN = 32'(MAX_BODY_BYTES);

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [31:0]       body_len, body_len_next;
  logic [7:0]        frame_kind, frame_kind_next;
  logic [63:0]       first_frame, first_frame_next;
  logic [31:0]       rate, rate_next;
  logic [7:0]        hold, hold_next;
  logic              streaming, streaming_next;
  logic              halted, halted_next;
  logic              ev_valid_next;
  ev_t               ev_next;

  logic [31:0]       len_shift;
  logic              len_bad;
  logic              len_last;
  logic [CNT_W-1:0]  idx_inc;
  logic              body_end;
  logic              pcm_ok;
  logic [31:0]       pay_len;
  logic [30:0]       pay_half;
  logic [COUNT_W-1:0] count_sat;
  logic              chg_req;
  logic              chg_val;

  assign len_shift = {body_len[23:0], data_byte};
  assign len_bad   = (len_shift == '0) || (len_shift > MAX_LEN);
  assign len_last  = (cnt[1:0] == 2'd3);
  assign idx_inc   = cnt + 1'b1;
  assign body_end  = (32'(idx_inc) >= body_len);
  // 13 is odd, so an even payload means an odd body length
  assign pcm_ok    = streaming && (rate >= 32'(min_rate)) && (rate <= 32'(max_rate))
                     && (body_len > 32'(HDR_BYTES)) && body_len[0];
  assign pay_len   = body_len - 32'(HDR_BYTES);
  assign pay_half  = pay_len[31:1];
  assign count_sat = (pay_half > 31'(COUNT_MAX)) ? COUNT_MAX : pay_half[COUNT_W-1:0];

  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      if (req_type) begin
        phase_next = PH_LEN;
      end else if (!halted) begin
        unique case (phase)
          PH_LEN: begin
            if (len_last && !len_bad) phase_next = PH_TYPE;
          end
          PH_TYPE: begin
            phase_next = (body_len <= 32'd1) ? PH_LEN : PH_BODY;
          end
          PH_BODY: begin
            if (body_end) phase_next = PH_LEN;
          end
          default: phase_next = PH_LEN;
        endcase
      end
    end
  end

  always_comb begin
    cnt_next         = cnt;
    body_len_next    = body_len;
    frame_kind_next  = frame_kind;
    first_frame_next = first_frame;
    rate_next        = rate;
    hold_next        = hold;
    streaming_next   = streaming;
    halted_next      = halted;
    ev_valid_next    = 1'b0;
    ev_next          = ev;
    chg_req          = 1'b0;
    chg_val          = 1'b0;

    if (in_valid) begin
      if (req_type) begin
        // connection reset: registers survive, parser and flag do not
        cnt_next         = '0;
        body_len_next    = '0;
        frame_kind_next  = '0;
        first_frame_next = '0;
        rate_next        = '0;
        hold_next        = '0;
        halted_next      = 1'b0;
        chg_req          = 1'b1;
        chg_val          = 1'b0;
      end else if (!halted) begin
        unique case (phase)
          PH_LEN: begin
            body_len_next = len_shift;
            cnt_next      = idx_inc;
            if (len_last) begin
              cnt_next = '0;
              if (len_bad) begin
                halted_next   = 1'b1;
                body_len_next = '0;
                ev_valid_next = 1'b1;
                ev_next       = '0;
                ev_next.kind  = KIND_LEN_ERR;
              end
            end
          end
          PH_TYPE: begin
            frame_kind_next  = data_byte;
            first_frame_next = '0;
            rate_next        = '0;
            hold_next        = '0;
            cnt_next         = CNT_W'(1);
            if (body_len <= 32'd1) begin
              cnt_next      = '0;
              body_len_next = '0;
              if (data_byte == TYPE_STOP) begin
                chg_req = 1'b1;
                chg_val = 1'b0;
              end
            end
          end
          PH_BODY: begin
            if (frame_kind == TYPE_CTRL) begin
              if (cnt == CNT_W'(CTRL_FLAG_IDX)) hold_next = data_byte;
            end else if (frame_kind == TYPE_AUDIO) begin
              if (cnt <= CNT_W'(START_LAST_IDX)) begin
                first_frame_next = {first_frame[55:0], data_byte};
              end else if (cnt < CNT_W'(HDR_BYTES)) begin
                rate_next = {rate[23:0], data_byte};
              end else if (pcm_ok) begin
                if (cnt[0]) begin
                  hold_next = data_byte;
                end else begin
                  ev_valid_next  = 1'b1;
                  ev_next        = '0;
                  ev_next.kind   = KIND_SAMPLE;
                  ev_next.sample = {data_byte, hold};
                  ev_next.start  = first_frame;
                  ev_next.rate   = rate[MAX_RATE_W-1:0];
                  ev_next.count  = count_sat;
                  ev_next.fin    = (32'(idx_inc) == body_len);
                  ev_next.first  = (cnt == CNT_W'(HDR_BYTES + 1));
                end
              end
            end
            cnt_next = idx_inc;
            if (body_end) begin
              cnt_next      = '0;
              body_len_next = '0;
              if ((frame_kind == TYPE_CTRL) && (body_len >= 32'd2)) begin
                chg_req = 1'b1;
                chg_val = (hold_next != 8'd0);
              end else if (frame_kind == TYPE_STOP) begin
                chg_req = 1'b1;
                chg_val = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      if (chg_req && (chg_val != streaming)) begin
        streaming_next = chg_val;
        ev_valid_next  = 1'b1;
        ev_next        = '0;
        ev_next.kind   = KIND_STREAM;
        ev_next.on     = chg_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEN;
      cnt         <= '0;
      body_len    <= '0;
      frame_kind  <= '0;
      first_frame <= '0;
      rate        <= '0;
      hold        <= '0;
      streaming   <= 1'b0;
      halted      <= 1'b0;
      ev_valid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      body_len    <= body_len_next;
      frame_kind  <= frame_kind_next;
      first_frame <= first_frame_next;
      rate        <= rate_next;
      hold        <= hold_next;
      streaming   <= streaming_next;
      halted      <= halted_next;
      ev_valid    <= ev_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ev <= ev_next;
  end

endmodule

`default_nettype wire

@@ sv/afd_energy.sv @@
`default_nettype none

module afd_energy (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ev_valid,
  input  wire afd_pkg::ev_t  ev,
  output logic               sq_valid,
  output logic               push,
  output afd_pkg::q_t        push_data
);
  import afd_pkg::*;

  logic signed [15:0]  smp;
  logic signed [31:0]  prod;
  logic [31:0]         sq;
  ev_t                 sq_ev;
  logic [ENERGY_W-1:0] acc;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] energy_new;

  assign smp  = ev.sample;
  assign prod = smp * smp;

  // square registered, accumulate in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_ev <= ev;
    sq    <= prod;
  end

  assign sum        = {1'b0, acc} + (ENERGY_W + 1)'(sq);
  assign energy_new = sq_ev.first ? ENERGY_W'(sq) : (sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0]);

  always_ff @(posedge clk) begin
    if (sq_valid && (sq_ev.kind == KIND_SAMPLE)) acc <= energy_new;
  end

  assign push = sq_valid;

  always_comb begin
    push_data.kind   = sq_ev.kind;
    push_data.sample = sq_ev.sample;
    push_data.start  = sq_ev.start;
    push_data.rate   = sq_ev.rate;
    push_data.on     = sq_ev.on;
    push_data.energy = energy_new;
    push_data.count  = sq_ev.count;
    push_data.fin    = sq_ev.fin;
  end

endmodule

`default_nettype wire

@@ sv/afd_fifo.sv @@
`default_nettype none

module afd_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire afd_pkg::q_t                 push_data,
  input  wire logic                        pop,
  output afd_pkg::q_t                      head,
  output logic                             head_valid,
  output logic [afd_pkg::FIFO_CW-1:0]      count
);
  import afd_pkg::*;

  q_t                 slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

@@ sv/afd_emit.sv @@
`default_nettype none

module afd_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire afd_pkg::q_t                 head,
  input  wire logic                        head_valid,
  output logic                             pop,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [afd_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import afd_pkg::*;

  logic                  sub, sub_next;
  logic                  tvalid_next;
  logic                  load;
  logic                  two;

  kind_t                 o_kind;
  logic [15:0]           o_sample;
  logic [63:0]           o_start;
  logic [MAX_RATE_W-1:0] o_rate;
  logic                  o_on;
  logic [ENERGY_W-1:0]   o_energy;
  logic [COUNT_W-1:0]    o_count;
  logic                  o_last;

  // a final sample leaves two transfers: the sample, then the energy report
  assign load = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign two  = (head.kind == KIND_SAMPLE) && head.fin;
  assign pop  = load && (sub || !two);

  always_comb begin
    sub_next    = sub;
    tvalid_next = m_axis_tvalid;
    if (load) begin
      sub_next    = !sub && two;
      tvalid_next = 1'b1;
    end else if (m_axis_tready) begin
      tvalid_next = 1'b0;
    end
  end

  always_comb begin
    o_kind   = head.kind;
    o_sample = '0;
    o_start  = '0;
    o_rate   = '0;
    o_on     = 1'b0;
    o_energy = '0;
    o_count  = '0;
    o_last   = 1'b0;
    if (sub) begin
      o_kind   = KIND_REPORT;
      o_start  = head.start;
      o_rate   = head.rate;
      o_energy = head.energy;
      o_count  = head.count;
    end else begin
      case (head.kind)
        KIND_SAMPLE: begin
          o_sample = head.sample;
          o_start  = head.start;
          o_rate   = head.rate;
          o_last   = head.fin;
        end
        KIND_STREAM: o_on = head.on;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      sub           <= 1'b0;
    end else begin
      m_axis_tvalid <= tvalid_next;
      sub           <= sub_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= OUT_W'({o_count, o_energy, o_on, o_rate, o_start, o_sample});
      m_axis_tuser <= o_kind;
      m_axis_tlast <= o_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/afd_checker.sv @@
`default_nettype none

module afd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [afd_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic [1:0]                m_axis_tuser,
  input wire logic                      m_axis_tlast
);
  import afd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_SAMPLE)
    else $error("tlast on a non-sample result");

  a_report_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == KIND_REPORT))
    else $error("final sample not followed by its energy report");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_SAMPLE) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("sample field set on a non-sample result");

endmodule

bind audio_frame_deframer afd_checker u_afd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
